FILE: rtl/core/switch_event_rate_limiter_defines.svh
// assertion macros shared by the rate limiter rtl
// needs clk and rst in the scope where a macro is used
`ifndef SWITCH_EVENT_RATE_LIMITER_DEFINES_SVH
`define SWITCH_EVENT_RATE_LIMITER_DEFINES_SVH
`ifndef SYNTHESIS
// property holds on every clock edge outside reset
`define SRL_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("srl assertion failed");
// consequent holds in the cycle after the antecedent
`define SRL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srl assertion failed");
`else
`define SRL_ASSERT(label, prop)
`define SRL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/core/srl_pkg.sv
// types and constants for the switch event rate limiter
// no dependencies
package srl_pkg;

  localparam int ID_W = 16;
  localparam int TIME_W = 32;
  localparam int CFG_W = 8;
  localparam int IDX_OUT_W = 3;
  localparam logic [CFG_W-1:0] MIN_INTERVAL_RESET = 8'd5;

  // one event beat
  typedef struct packed {
    logic              mode;
    logic [ID_W-1:0]   sensor_id;
    logic [TIME_W-1:0] now_seconds;
  } ev_t;

  // one result beat
  typedef struct packed {
    logic                 trigger;
    logic [IDX_OUT_W-1:0] entry_index;
    logic                 was_new;
    logic                 dropped;
  } res_t;

  // status passed from cell to cell
  typedef struct packed {
    logic hit;
    logic trig;
  } chain_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_t;

endpackage

FILE: rtl/core/srl_cell.sv
// one table slot of the rate limiter: id, last on time, on flag
// depends on srl_pkg
module srl_cell #(
  parameter int IDX_W = 3,
  parameter int CNT_W = 4,
  parameter int IDX   = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  srl_pkg::ev_t                key,
  input  logic [srl_pkg::CFG_W-1:0]   min_interval,
  input  logic [CNT_W-1:0]            used_count,
  input  logic                        miss,
  input  logic                        commit,
  input  srl_pkg::chain_t             chain_in,
  input  logic [IDX_W-1:0]            idx_in,
  output srl_pkg::chain_t             chain_out,
  output logic [IDX_W-1:0]            idx_out
);

  logic                         occ;
  logic                         is_on;
  logic [srl_pkg::ID_W-1:0]     id;
  logic [srl_pkg::TIME_W-1:0]   last_on;
  logic [srl_pkg::TIME_W-1:0]   elapsed;
  logic                         match;
  logic                         trig_here;
  logic                         claim;

  // compare against the event key and check the hold-off time
  always_comb begin
    match     = occ && (id == key.sensor_id);
    elapsed   = key.now_seconds - last_on;
    trig_here = match && key.mode && !is_on &&
                (elapsed > srl_pkg::TIME_W'(min_interval));
    claim     = commit && miss && !occ && (used_count == CNT_W'(IDX));
  end

  // hand hit status and slot index to the next cell
  always_comb begin
    chain_out.hit  = chain_in.hit | match;
    chain_out.trig = chain_in.trig | trig_here;
    idx_out        = match ? IDX_W'(IDX) : idx_in;
  end

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      occ   <= 1'b0;
      is_on <= 1'b0;
    end else if (claim) begin
      occ   <= 1'b1;
      is_on <= key.mode;
    end else if (commit && match) begin
      is_on <= key.mode;
    end
  end

  // slot payload
  always_ff @(posedge clk) begin
    if (claim) begin
      id      <= key.sensor_id;
      last_on <= key.mode ? key.now_seconds : '0;
    end else if (commit && match && key.mode && !is_on) begin
      last_on <= key.now_seconds;
    end
  end

endmodule

FILE: rtl/core/switch_event_rate_limiter.sv
// switch event rate limiter top level: handshake, config and cell row
// depends on srl_pkg, srl_cell and switch_event_rate_limiter_defines.svh
//
// usage:
//   ev channel (ev_valid/ev_ready/ev) carries mode, sensor id and time in
//   seconds. res channel (res_valid/res_ready/res) returns one result beat
//   per event: trigger, entry index, was_new and dropped.
//   cfg_we/cfg_wdata write min_interval (reset value 5) while idle.
// flow: an accepted event beat is registered as the key; in state LOOK
//   every slot cell compares it in parallel while the hit and trigger
//   status ripple down the cell row, then it commits and res_valid rises
//   once any pending result is taken. no new event is taken until then.
// reset: all slots empty, min_interval back to 5, no result pending.
// stall: the result sits in an output register; a new event is still
//   taken, but it cannot commit until the pending result has been taken,
//   so ev_ready stays low while that event waits.
`include "switch_event_rate_limiter_defines.svh"
module switch_event_rate_limiter #(
  parameter int ENTRIES = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      ev_valid,
  output logic                      ev_ready,
  input  srl_pkg::ev_t              ev,
  output logic                      res_valid,
  input  logic                      res_ready,
  output srl_pkg::res_t             res,
  input  logic                      cfg_we,
  input  logic [srl_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  srl_pkg::state_t            state;
  srl_pkg::state_t            state_next;
  srl_pkg::ev_t               key;
  logic [srl_pkg::CFG_W-1:0]  min_interval;
  logic [CNT_W-1:0]           used_count;
  logic                       res_valid_next;
  logic                       commit;
  logic                       miss;
  logic                       full;
  srl_pkg::chain_t            chain [ENTRIES+1];
  logic [IDX_W-1:0]           idx_c [ENTRIES+1];
  logic [IDX_W-1:0]           sel_idx;
  logic [IDX_W+2:0]           sel_ext;
  srl_pkg::res_t              res_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      srl_pkg::ST_IDLE: begin
        if (ev_valid) state_next = srl_pkg::ST_LOOK;
      end
      srl_pkg::ST_LOOK: begin
        if (commit) state_next = srl_pkg::ST_IDLE;
      end
      default: state_next = srl_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    ev_ready = 1'b0;
    commit   = 1'b0;
    case (state)
      srl_pkg::ST_IDLE: ev_ready = 1'b1;
      srl_pkg::ST_LOOK: commit   = !res_valid || res_ready;
      default: begin
        ev_ready = 1'b0;
        commit   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= srl_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // event key capture
  always_ff @(posedge clk) begin
    if (ev_valid && ev_ready) key <= ev;
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst)         min_interval <= srl_pkg::MIN_INTERVAL_RESET;
    else if (cfg_we) min_interval <= cfg_wdata;
  end

  // row of slot cells
  assign chain[0] = '0;
  assign idx_c[0] = '0;
  assign miss     = !chain[ENTRIES].hit;
  assign full     = (used_count == CNT_W'(ENTRIES));

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    srl_cell #(
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .key          (key),
      .min_interval (min_interval),
      .used_count   (used_count),
      .miss         (miss),
      .commit       (commit),
      .chain_in     (chain[i]),
      .idx_in       (idx_c[i]),
      .chain_out    (chain[i+1]),
      .idx_out      (idx_c[i+1])
    );
  end

  // result for the event in flight
  always_comb begin
    sel_idx = miss ? used_count[IDX_W-1:0] : idx_c[ENTRIES];
    sel_ext = {3'b000, sel_idx};
    res_next.trigger     = 1'b0;
    res_next.entry_index = '0;
    res_next.was_new     = 1'b0;
    res_next.dropped     = 1'b0;
    if (!miss) begin
      res_next.trigger     = chain[ENTRIES].trig;
      res_next.entry_index = sel_ext[srl_pkg::IDX_OUT_W-1:0];
    end else if (!full) begin
      res_next.trigger     = key.mode;
      res_next.entry_index = sel_ext[srl_pkg::IDX_OUT_W-1:0];
      res_next.was_new     = 1'b1;
    end else begin
      res_next.dropped     = 1'b1;
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst)                          used_count <= '0;
    else if (commit && miss && !full) used_count <= used_count + 1'b1;
  end

  // output register
  assign res_valid_next = commit || (res_valid && !res_ready);

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else     res_valid <= res_valid_next;
  end

  always_ff @(posedge clk) begin
    if (commit) res <= res_next;
  end

  // checks
  `SRL_ASSERT(a_no_overwrite, !(res_valid && !res_ready && commit))
  `SRL_ASSERT(a_count_bound, used_count <= CNT_W'(ENTRIES))
  `SRL_ASSERT(a_drop_clean, !(res_valid && res.dropped && (res.trigger || res.was_new)))
  `SRL_ASSERT_NEXT(a_take_to_look, ev_valid && ev_ready, state == srl_pkg::ST_LOOK)
  `SRL_ASSERT_NEXT(a_commit_result, commit, res_valid)

endmodule
